@@ hdl/hcs_pkg.sv @@
// hcs_pkg: shared constants and types for the hamiltonian cycle search unit
// no dependencies; every other file of the block imports it
package hcs_pkg;

    localparam int ROWS         = 16;
    localparam int MAX_VERTICES = 16;
    localparam int VTX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    // largest vertex count the search can use
    localparam logic [CNT_W-1:0] COUNT_CAP =
        (MAX_VERTICES < ROWS) ? CNT_W'(MAX_VERTICES) : CNT_W'(ROWS);

    // register index, taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(16);

    typedef logic [ROWS-1:0]  row_t;
    typedef logic [VTX_W-1:0] vtx_t;

    // adjacency row write from the input channel
    typedef struct packed {
        logic en;
        vtx_t row;
        row_t bits;
    } adj_wr_t;

endpackage

@@ hdl/hcs_in_if.sv @@
// hcs_in_if: input channel carrying one adjacency row per transfer
// depends on hcs_pkg
interface hcs_in_if
    import hcs_pkg::*;
;
    logic valid;
    logic ready;
    vtx_t row_index;
    row_t row_bits;
    logic start_req;

    modport source (output valid, output row_index, output row_bits, output start_req,
                    input ready);
    modport sink (input valid, input row_index, input row_bits, input start_req,
                  output ready);
endinterface

@@ hdl/hcs_out_if.sv @@
// hcs_out_if: result channel carrying one cycle vertex per transfer
// depends on hcs_pkg
interface hcs_out_if
    import hcs_pkg::*;
;
    logic valid;
    logic ready;
    logic found;
    vtx_t vertex;
    logic last;

    modport source (output valid, output found, output vertex, output last, input ready);
    modport sink (input valid, input found, input vertex, input last, output ready);
endinterface

@@ hdl/hcs_cfg_regs.sv @@
// hcs_cfg_regs: apb register port holding vertex_count and driving the clamped count
// depends on hcs_pkg
module hcs_cfg_regs
    import hcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CNT_W-1:0]      count_eff
);

    logic [CNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0] vertex_count_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);

    always_comb
    begin
        vertex_count_next = vertex_count_reg;
        if (wr_en)
        begin
            vertex_count_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_VERTEX_COUNT)
        begin
            prdata = CFG_DATA_W'(vertex_count_reg);
        end
    end

    assign count_eff = (vertex_count_reg > COUNT_CAP) ? COUNT_CAP : vertex_count_reg;

endmodule

@@ hdl/hcs_adj_store.sv @@
// hcs_adj_store: adjacency matrix in flip-flops, one row written and one row read
// depends on hcs_pkg
module hcs_adj_store
    import hcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  adj_wr_t wr,
    input  vtx_t    rd_row,
    output row_t    rd_bits
);

    row_t adj_reg [ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            adj_reg[wr.row] <= wr.bits;
        end
    end

    assign rd_bits = adj_reg[rd_row];

endmodule

@@ hdl/hcs_search.sv @@
// hcs_search: backtracking sequencer with path stack memory and result register
// depends on hcs_pkg; reads rows from hcs_adj_store
module hcs_search
    import hcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] count_eff,
    output logic             idle,
    output vtx_t             adj_row,
    input  row_t             adj_bits,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_found,
    output vtx_t             out_vertex,
    output logic             out_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_POP,
        S_TAIL,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] v_reg, v_next;
    vtx_t             tail_reg, tail_next;
    vtx_t             k_reg, k_next;
    row_t             used_reg, used_next;
    logic             valid_reg, valid_next;
    logic             found_reg, found_next;
    vtx_t             vertex_reg, vertex_next;
    logic             last_reg, last_next;

    // path stack
    vtx_t             path_mem [ROWS];
    vtx_t             path_rdata_reg;
    logic             path_we;
    vtx_t             path_waddr;
    vtx_t             path_wdata;
    vtx_t             path_raddr;

    logic [CNT_W-1:0] d_dec;
    logic             cand_ok;

    assign d_dec   = d_reg - CNT_W'(1);
    assign adj_row = tail_reg;
    assign cand_ok = adj_bits[v_reg[VTX_W-1:0]] && !used_reg[v_reg[VTX_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_rdata_reg <= path_mem[path_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        v_next      = v_reg;
        tail_next   = tail_reg;
        k_next      = k_reg;
        used_next   = used_reg;
        valid_next  = valid_reg;
        found_next  = found_reg;
        vertex_next = vertex_reg;
        last_next   = last_reg;
        path_we     = 1'b0;
        path_waddr  = d_reg[VTX_W-1:0];
        path_wdata  = v_reg[VTX_W-1:0];
        path_raddr  = d_dec[VTX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = count_eff;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (n_reg == '0)
                begin
                    valid_next  = 1'b1;
                    found_next  = 1'b0;
                    vertex_next = '0;
                    last_next   = 1'b1;
                    used_next   = '0;
                    d_next      = '0;
                    state_next  = S_EMIT_WAIT;
                end
                else
                begin
                    path_we    = 1'b1;
                    path_waddr = '0;
                    path_wdata = '0;
                    used_next  = row_t'(1);
                    d_next     = CNT_W'(1);
                    v_next     = CNT_W'(1);
                    tail_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (d_reg == n_reg && adj_bits[0])
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else if (d_reg != n_reg && v_reg < n_reg && cand_ok)
                begin
                    // push candidate
                    path_we    = 1'b1;
                    used_next  = used_reg | (row_t'(1) << v_reg[VTX_W-1:0]);
                    tail_next  = v_reg[VTX_W-1:0];
                    d_next     = d_reg + CNT_W'(1);
                    v_next     = CNT_W'(1);
                end
                else if (d_reg != n_reg && v_reg < n_reg)
                begin
                    v_next = v_reg + CNT_W'(1);
                end
                else
                begin
                    // backtrack: read the vertex being popped
                    d_next = d_dec;
                    if (d_dec == '0)
                    begin
                        valid_next  = 1'b1;
                        found_next  = 1'b0;
                        vertex_next = '0;
                        last_next   = 1'b1;
                        state_next  = S_EMIT_WAIT;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                // read the new tail at d-1
                used_next  = used_reg & ~(row_t'(1) << path_rdata_reg);
                v_next     = {1'b0, path_rdata_reg} + CNT_W'(1);
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                tail_next  = path_rdata_reg;
                state_next = S_SCAN;
            end
            S_EMIT_RD:
            begin
                path_raddr = k_reg;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                valid_next  = 1'b1;
                found_next  = 1'b1;
                vertex_next = path_rdata_reg;
                last_next   = ({1'b0, k_reg} == d_dec);
                state_next  = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + VTX_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            d_reg      <= '0;
            v_reg      <= '0;
            tail_reg   <= '0;
            k_reg      <= '0;
            used_reg   <= '0;
            valid_reg  <= 1'b0;
            found_reg  <= 1'b0;
            vertex_reg <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            d_reg      <= d_next;
            v_reg      <= v_next;
            tail_reg   <= tail_next;
            k_reg      <= k_next;
            used_reg   <= used_next;
            valid_reg  <= valid_next;
            found_reg  <= found_next;
            vertex_reg <= vertex_next;
            last_reg   <= last_next;
        end
    end

    assign idle       = (state_reg == S_IDLE);
    assign out_valid  = valid_reg;
    assign out_found  = found_reg;
    assign out_vertex = vertex_reg;
    assign out_last   = last_reg;

endmodule

@@ hdl/hamiltonian_cycle_search_unit.sv @@
// channel  dir  payload                          transfer when
// in_ch    in   row_index, row_bits, start_req   valid && ready
// out_ch   out  found, vertex, last              valid && ready
// apb      in   vertex_count at byte address 0   psel && penable && pwrite
//
// a row without start_req is stored at its transfer and the next row can follow at once
// with start_req the block is busy: S_START, then the sequencer tries one candidate
// per cycle, backtracks via S_SCAN, S_POP, S_TAIL and emits each vertex via S_EMIT_RD,
// S_EMIT_LD, S_EMIT_WAIT plus any output stall; run time grows with the search tree
// reset clears the adjacency matrix and sets vertex_count to 16
// depends on hcs_pkg, hcs_in_if, hcs_out_if, hcs_cfg_regs, hcs_adj_store, hcs_search
module hamiltonian_cycle_search_unit
    import hcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    hcs_in_if.sink                in_ch,
    hcs_out_if.source             out_ch
);

    logic             idle;
    logic [CNT_W-1:0] count_eff;
    adj_wr_t          adj_wr;
    vtx_t             adj_row;
    row_t             adj_bits;
    logic             in_xfer;

    assign in_ch.ready = idle;
    assign in_xfer     = in_ch.valid && idle;

    assign adj_wr.en   = in_xfer;
    assign adj_wr.row  = in_ch.row_index;
    assign adj_wr.bits = in_ch.row_bits;

    hcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .count_eff (count_eff)
    );

    hcs_adj_store u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (adj_wr),
        .rd_row  (adj_row),
        .rd_bits (adj_bits)
    );

    hcs_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_xfer && in_ch.start_req),
        .count_eff  (count_eff),
        .idle       (idle),
        .adj_row    (adj_row),
        .adj_bits   (adj_bits),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_found  (out_ch.found),
        .out_vertex (out_ch.vertex),
        .out_last   (out_ch.last)
    );

endmodule

@@ tb/tb_hamiltonian_cycle_search_unit.sv @@
`timescale 1ns / 100ps
// tb_hamiltonian_cycle_search_unit: self-checking testbench for the cycle search unit
// predicts every emitted cycle vertex, and each not-found result, with its own backtracking search
// depends on hcs_pkg, hcs_in_if, hcs_out_if and hamiltonian_cycle_search_unit
module tb_hamiltonian_cycle_search_unit;
    import hcs_pkg::*;

    localparam int LIMIT_CYCLES  = 2000000;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [CFG_ADDR_W-1:0] VC_ADDR     = {REG_VERTEX_COUNT, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = {~REG_VERTEX_COUNT, 2'b00};

    typedef struct packed {
        logic found;
        vtx_t vertex;
        logic last;
    } cycle_step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    hcs_in_if  in_bus ();
    hcs_out_if out_bus ();

    hamiltonian_cycle_search_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (out_bus)
    );

    // shadow of the block state
    row_t        adj_copy [ROWS];
    logic [CNT_W-1:0] count_reg;
    vtx_t        tour [ROWS];
    row_t        visited;

    cycle_step_t cycle_q [$];
    int          error_count;
    int          cycle_count;
    int          hold_request;
    bit          idle_in;
    bit          idle_out;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** hamiltonian_cycle_search_unit: FAILED **");
            $finish;
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // depth-first extension of the tour, candidates in ascending order
    function automatic bit extend_tour(int depth, int n);
        int cand;
        if (depth == n)
            return adj_copy[tour[n-1]][0];
        for (cand = 1; cand < n; cand++)
        begin
            if (adj_copy[tour[depth-1]][cand] && !visited[cand])
            begin
                tour[depth] = vtx_t'(cand);
                visited[cand] = 1'b1;
                if (extend_tour(depth + 1, n))
                    return 1'b1;
                visited[cand] = 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_search();
        int          n;
        int          k;
        cycle_step_t step;
        n = (count_reg > COUNT_CAP) ? int'(COUNT_CAP) : int'(count_reg);
        tour[0] = '0;
        visited = row_t'(1);
        if (n != 0 && extend_tour(1, n))
        begin
            for (k = 0; k < n; k++)
            begin
                step.found  = 1'b1;
                step.vertex = tour[k];
                step.last   = (k == n - 1);
                cycle_q.push_back(step);
            end
        end
        else
        begin
            step.found  = 1'b0;
            step.vertex = '0;
            step.last   = 1'b1;
            cycle_q.push_back(step);
        end
    endfunction

    // result side: random stall per result while idle_out is set, plus an optional long hold-off
    initial
    begin : ready_drive
        int gap;
        out_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                out_bus.ready = 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            gap = idle_out ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                out_bus.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_bus.ready = 1'b1;
            @(posedge clk);
            while (!out_bus.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        cycle_step_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (cycle_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got found=%0d vertex=%0d last=%0d",
                         $time, out_bus.found, out_bus.vertex, out_bus.last);
                error_count++;
            end
            else
            begin
                want = cycle_q.pop_front();
                check_field("found", int'(want.found), int'(out_bus.found));
                check_field("vertex", int'(want.vertex), int'(out_bus.vertex));
                check_field("last", int'(want.last), int'(out_bus.last));
            end
        end
    end

    task automatic send_row(int idx, row_t bits, bit start);
        int gap;
        gap = idle_in ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.valid     = 1'b1;
        in_bus.row_index = vtx_t'(idx);
        in_bus.row_bits  = bits;
        in_bus.start_req = start;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        adj_copy[idx] = bits;
        if (start)
            predict_search();
    endtask

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == VC_ADDR)
            count_reg = data[CNT_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = VC_ADDR;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("vertex_count readback", int'(count_reg), int'(prdata));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // drop valid, wait for every expected result, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_bus.valid = 1'b0;
        while (cycle_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void shuffle_range(ref int seq[ROWS], input int lo, input int hi);
        int i;
        int j;
        int tmp;
        for (i = hi; i > lo; i--)
        begin
            j = $urandom_range(lo, i);
            tmp = seq[i];
            seq[i] = seq[j];
            seq[j] = tmp;
        end
    endfunction

    // loads rows 0..n-1 in random order, the last one optionally starting the search
    task automatic load_graph(int n, bit with_start);
        row_t rows [ROWS];
        int   seq [ROWS];
        int   style;
        int   i;
        style = $urandom_range(0, 4);
        for (i = 0; i < ROWS; i++)
        begin
            case (style)
                0, 3:    rows[i] = row_t'($urandom & $urandom);
                1:       rows[i] = row_t'($urandom);
                2:       rows[i] = row_t'($urandom | $urandom);
                default: rows[i] = row_t'($urandom & $urandom & $urandom);
            endcase
            seq[i] = i;
        end
        // plant a random cycle so that a hit is guaranteed
        if (style >= 3)
        begin
            shuffle_range(seq, 1, n - 1);
            for (i = 0; i < n; i++)
                rows[seq[i]][seq[(i + 1) % n]] = 1'b1;
            for (i = 0; i < ROWS; i++)
                seq[i] = i;
        end
        shuffle_range(seq, 0, n - 1);
        for (i = 0; i < n; i++)
            send_row(seq[i], rows[seq[i]], with_start && (i == n - 1));
    endtask

    task automatic test_reset_defaults();
        apb_read_check();
        // rows are cleared by reset, so vertex 0 has no way out
        send_row(15, 16'h0000, 1'b1);
    endtask

    task automatic test_full_ring();
        int v;
        settle();
        for (v = 0; v < ROWS; v++)
            send_row(v, row_t'(1) << ((v + 1) % ROWS), v == ROWS - 1);
    endtask

    task automatic test_count_limits();
        settle();
        apb_write(VC_ADDR, 32'd31);
        apb_write(UNUSED_ADDR, 32'd3);
        apb_read_check();
        send_row(15, 16'h0001, 1'b1);
        settle();
        apb_write(VC_ADDR, 32'hFFFF_FFF0);
        apb_read_check();
    endtask

    task automatic test_count_zero();
        settle();
        apb_write(VC_ADDR, 32'd0);
        apb_read_check();
        send_row(0, 16'hFFFF, 1'b1);
    endtask

    task automatic test_small_counts();
        settle();
        apb_write(VC_ADDR, 32'd1);
        send_row(0, 16'h0000, 1'b1);
        send_row(0, 16'h0001, 1'b1);
        settle();
        apb_write(VC_ADDR, 32'd2);
        send_row(1, 16'h0001, 1'b0);
        send_row(0, 16'h0002, 1'b1);
        // first branch dead-ends at vertex 2, second branch closes the cycle
        settle();
        apb_write(VC_ADDR, 32'd4);
        send_row(1, 16'b1000, 1'b0);
        send_row(2, 16'b0010, 1'b0);
        send_row(3, 16'b0101, 1'b0);
        send_row(0, 16'b0110, 1'b1);
    endtask

    task automatic test_backpressure();
        int v;
        settle();
        apb_write(VC_ADDR, 32'd5);
        idle_in  = 1'b0;
        idle_out = 1'b0;
        hold_request = HOLD_CYCLES;
        for (v = 0; v < 5; v++)
            send_row(v, 16'hFFFF, v == 4);
        for (v = 0; v < 6; v++)
            send_row($urandom_range(0, 4), 16'hFFFF, 1'b1);
        idle_in  = 1'b1;
        idle_out = 1'b1;
    endtask

    task automatic test_random(int target);
        int sent;
        int n;
        int pick;
        sent = 0;
        while (sent < target)
        begin
            settle();
            n = $urandom_range(1, 6);
            apb_write(VC_ADDR, CFG_DATA_W'(n));
            if ($urandom_range(0, 3) == 0)
                apb_read_check();
            idle_in  = $urandom_range(0, 2) != 0;
            idle_out = $urandom_range(0, 2) != 0;
            repeat ($urandom_range(3, 8))
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    send_row($urandom_range(0, 15), row_t'($urandom), $urandom_range(0, 2) == 0);
                    sent++;
                end
                else if (pick == 1)
                begin
                    // full load of n rows, no start
                    load_graph(n, 1'b0);
                    sent += n;
                end
                else if (pick == 2)
                begin
                    // search again over the stored rows
                    send_row($urandom_range(n, 15), row_t'($urandom), 1'b1);
                    sent++;
                end
                else
                begin
                    load_graph(n, 1'b1);
                    sent += n;
                end
            end
        end
    endtask

    task automatic finish_run();
        int waited;
        @(negedge clk);
        in_bus.valid = 1'b0;
        waited = 0;
        while (cycle_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (cycle_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, cycle_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** hamiltonian_cycle_search_unit: PASSED **");
        else
            $display("** hamiltonian_cycle_search_unit: FAILED **");
        $finish;
    endtask

    initial
    begin
        int i;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_bus.valid     = 1'b0;
        in_bus.row_index = '0;
        in_bus.row_bits  = '0;
        in_bus.start_req = 1'b0;
        error_count      = 0;
        cycle_count      = 0;
        hold_request     = 0;
        idle_in          = 1'b1;
        idle_out         = 1'b1;
        count_reg        = VERTEX_COUNT_RESET;
        visited          = '0;
        for (i = 0; i < ROWS; i++)
        begin
            adj_copy[i] = '0;
            tour[i]     = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_full_ring();
        test_count_limits();
        test_count_zero();
        test_small_counts();
        test_backpressure();
        test_random(480);
        finish_run();
    end

endmodule

@@ filelist.f @@
hdl/hcs_pkg.sv
hdl/hcs_in_if.sv
hdl/hcs_out_if.sv
hdl/hcs_cfg_regs.sv
hdl/hcs_adj_store.sv
hdl/hcs_search.sv
hdl/hamiltonian_cycle_search_unit.sv
tb/tb_hamiltonian_cycle_search_unit.sv
